[rtl/typed_rpn_stack_calculator_assert.svh]
// Assertion macros for the typed RPN stack calculator.
`ifndef TYPED_RPN_STACK_CALCULATOR_ASSERT_SVH
`define TYPED_RPN_STACK_CALCULATOR_ASSERT_SVH

// Clocked assertion, disabled while reset is applied.
`define TRSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define TRSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/trsc_pkg.sv]
// Shared types and constants of the typed RPN stack calculator.
package trsc_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int ENTRY_W     = 33;

  typedef enum logic [4:0] {
    CMD_PUSH_INT = 5'd0,
    CMD_TRUE     = 5'd1,
    CMD_FALSE    = 5'd2,
    CMD_ADD      = 5'd3,
    CMD_SUB      = 5'd4,
    CMD_MUL      = 5'd5,
    CMD_DIV      = 5'd6,
    CMD_MOD      = 5'd7,
    CMD_EQ       = 5'd8,
    CMD_LT       = 5'd9,
    CMD_GT       = 5'd10,
    CMD_LE       = 5'd11,
    CMD_GE       = 5'd12,
    CMD_NOT      = 5'd13,
    CMD_SWAP     = 5'd14,
    CMD_PRINT    = 5'd15,
    CMD_CLEAR    = 5'd16,
    CMD_DROP     = 5'd17,
    CMD_DUP      = 5'd18
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_NOT_INT  = 3'd2,
    ST_DIV_ZERO = 3'd3,
    ST_NOT_BOOL = 3'd4,
    ST_FULL     = 3'd5
  } status_e;

  typedef enum logic {RD_TOP, RD_SECOND} rd_sel_e;
  typedef enum logic [1:0] {WA_TOP, WA_M1, WA_M2} wa_sel_e;
  typedef enum logic [2:0] {WD_PUSH, WD_TRUE, WD_FALSE, WD_ALU, WD_R, WD_L} wd_sel_e;
  typedef enum logic [2:0] {CNT_HOLD, CNT_CLR, CNT_INC, CNT_DEC1, CNT_DEC2} cnt_op_e;

  typedef struct packed {
    logic    load_in;
    rd_sel_e rd_sel;
    logic    latch_r;
    logic    latch_l;
    cmd_e    op;
    logic    div_start;
    logic    wr_en;
    wa_sel_e wa;
    wd_sel_e wd;
    cnt_op_e cnt;
    logic    out_load;
    logic    print;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_one;
    logic full;
    logic r_bool;
    logic l_bool;
    logic r_zero;
    logic div_done;
  } dp_stat_t;

endpackage

[rtl/trsc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module trsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[rtl/trsc_div.sv]
// Iterative unsigned restoring divider, one quotient bit per cycle.
module trsc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic [31:0] quotient_o,
  output logic [31:0] remainder_o,
  output logic        done_o
);

  logic [31:0] rem_q, rem_d, quo_q, quo_d, dvs_q;
  logic [4:0]  cnt_q;
  logic        run_q, done_q;
  logic [32:0] shifted, trial;

  assign shifted = {rem_q, quo_q[31]};
  assign trial   = shifted - {1'b0, dvs_q};

  always_comb begin
    if (!trial[32]) begin
      rem_d = trial[31:0];
      quo_d = {quo_q[30:0], 1'b1};
    end else begin
      rem_d = shifted[31:0];
      quo_d = {quo_q[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '1;
      end else if (run_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign done_o      = done_q;

endmodule

[rtl/trsc_datapath.sv]
// Datapath: entry RAM, depth counter, operand registers, ALU and divider.
module trsc_datapath import trsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  input  logic [31:0] push_value_i,
  output dp_stat_t    stat_o,
  output logic        print_valid_o,
  output logic        print_is_bool_o,
  output logic [31:0] print_value_o,
  output logic [6:0]  stack_depth_o
);

  logic [CNT_W-1:0]   count_q, count_d;
  logic [31:0]        val_q;
  logic [ENTRY_W-1:0] r_q, l_q, rdata, wdata, alu;
  logic [ADDR_W-1:0]  addr_top, addr_m1, addr_m2, raddr, waddr;
  logic               pv_q, pb_q;
  logic [31:0]        pval_q;
  logic signed [31:0] ls, rs;
  logic [31:0]        prod, lmag, rmag, quo, rem, quo_s, rem_s;
  logic               div_done;

  assign addr_top = ADDR_W'(count_q);
  assign addr_m1  = ADDR_W'(count_q - 1);
  assign addr_m2  = ADDR_W'(count_q - 2);
  assign raddr    = (cmd_i.rd_sel == RD_TOP) ? addr_m1 : addr_m2;

  always_comb begin
    case (cmd_i.wa)
      WA_TOP:  waddr = addr_top;
      WA_M1:   waddr = addr_m1;
      default: waddr = addr_m2;
    endcase
  end

  assign ls    = signed'(l_q[31:0]);
  assign rs    = signed'(r_q[31:0]);
  assign prod  = l_q[31:0] * r_q[31:0];
  assign lmag  = l_q[31] ? -l_q[31:0] : l_q[31:0];
  assign rmag  = r_q[31] ? -r_q[31:0] : r_q[31:0];
  assign quo_s = (l_q[31] ^ r_q[31]) ? -quo : quo;
  assign rem_s = l_q[31] ? -rem : rem;

  always_comb begin
    case (cmd_i.op)
      CMD_ADD: alu = {1'b0, l_q[31:0] + r_q[31:0]};
      CMD_SUB: alu = {1'b0, l_q[31:0] - r_q[31:0]};
      CMD_MUL: alu = {1'b0, prod};
      CMD_DIV: alu = {1'b0, quo_s};
      CMD_MOD: alu = {1'b0, rem_s};
      CMD_EQ:  alu = {1'b1, 31'd0, r_q == l_q};
      CMD_LT:  alu = {1'b1, 31'd0, ls < rs};
      CMD_GT:  alu = {1'b1, 31'd0, ls > rs};
      CMD_LE:  alu = {1'b1, 31'd0, ls <= rs};
      CMD_GE:  alu = {1'b1, 31'd0, ls >= rs};
      CMD_NOT: alu = {1'b1, 31'd0, ~r_q[0]};
      default: alu = '0;
    endcase
  end

  always_comb begin
    case (cmd_i.wd)
      WD_PUSH:  wdata = {1'b0, val_q};
      WD_TRUE:  wdata = {1'b1, 32'd1};
      WD_FALSE: wdata = {1'b1, 32'd0};
      WD_ALU:   wdata = alu;
      WD_R:     wdata = r_q;
      default:  wdata = l_q;
    endcase
  end

  always_comb begin
    case (cmd_i.cnt)
      CNT_CLR:  count_d = '0;
      CNT_INC:  count_d = count_q + CNT_W'(1);
      CNT_DEC1: count_d = count_q - CNT_W'(1);
      CNT_DEC2: count_d = count_q - CNT_W'(2);
      default:  count_d = count_q;
    endcase
  end

  trsc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  trsc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (lmag),
    .divisor_i   (rmag),
    .quotient_o  (quo),
    .remainder_o (rem),
    .done_o      (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pv_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.out_load) begin
        pv_q <= cmd_i.print;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) val_q <= push_value_i;
    if (cmd_i.latch_r) r_q <= rdata;
    if (cmd_i.latch_l) l_q <= rdata;
    if (cmd_i.out_load) begin
      pb_q   <= cmd_i.print & r_q[32];
      pval_q <= cmd_i.print ? r_q[31:0] : 32'd0;
    end
  end

  assign stat_o.cnt_zero = (count_q == '0);
  assign stat_o.cnt_one  = (count_q == CNT_W'(1));
  assign stat_o.full     = (count_q == CNT_W'(STACK_DEPTH));
  assign stat_o.r_bool   = r_q[32];
  assign stat_o.l_bool   = l_q[32];
  assign stat_o.r_zero   = (r_q[31:0] == 32'd0);
  assign stat_o.div_done = div_done;

  assign print_valid_o   = pv_q;
  assign print_is_bool_o = pb_q;
  assign print_value_o   = pval_q;
  assign stack_depth_o   = 7'(count_q);

endmodule

[rtl/trsc_ctrl.sv]
// Controller: sequences reads, checks, writes and result strobe per request.
module trsc_ctrl import trsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [4:0] command_i,
  input  dp_stat_t   stat_i,
  output dp_cmd_t    cmd_o,
  output logic       busy_o,
  output logic       done_o,
  output logic [2:0] status_o
);

  typedef enum logic [2:0] {S_IDLE, S_RD2, S_RDL, S_EXEC, S_DIVW, S_WR2} state_e;

  state_e  state_q, state_d;
  cmd_e    cmd_q;
  status_e st, status_q;
  logic    fin, done_q;
  logic    bad_int;

  assign bad_int = stat_i.r_bool | stat_i.l_bool;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.op = cmd_q;
    st      = ST_OK;
    fin     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load_in = 1'b1;
          cmd_o.rd_sel  = RD_TOP;
          state_d       = S_RD2;
        end
      end
      S_RD2: begin
        cmd_o.latch_r = 1'b1;
        cmd_o.rd_sel  = RD_SECOND;
        state_d       = S_RDL;
      end
      S_RDL: begin
        cmd_o.latch_l = 1'b1;
        state_d       = S_EXEC;
      end
      S_EXEC: begin
        fin     = 1'b1;
        state_d = S_IDLE;
        unique case (cmd_q) inside
          CMD_PUSH_INT, CMD_TRUE, CMD_FALSE: begin
            if (stat_i.full) begin
              st = ST_FULL;
            end else begin
              cmd_o.wr_en = 1'b1;
              cmd_o.wa    = WA_TOP;
              cmd_o.wd    = (cmd_q == CMD_PUSH_INT) ? WD_PUSH :
                            (cmd_q == CMD_TRUE) ? WD_TRUE : WD_FALSE;
              cmd_o.cnt   = CNT_INC;
            end
          end
          CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD, CMD_EQ, CMD_LT, CMD_GT,
          CMD_LE, CMD_GE, CMD_SWAP: begin
            if (stat_i.cnt_zero) begin
              st = ST_EMPTY;
            end else if (stat_i.cnt_one) begin
              st        = ST_EMPTY;
              cmd_o.cnt = CNT_DEC1;
            end else if (cmd_q != CMD_EQ && cmd_q != CMD_SWAP && bad_int) begin
              st        = ST_NOT_INT;
              cmd_o.cnt = CNT_DEC2;
            end else if ((cmd_q == CMD_DIV || cmd_q == CMD_MOD) && stat_i.r_zero) begin
              st        = ST_DIV_ZERO;
              cmd_o.cnt = CNT_DEC2;
            end else if (cmd_q == CMD_DIV || cmd_q == CMD_MOD) begin
              fin             = 1'b0;
              cmd_o.div_start = 1'b1;
              state_d         = S_DIVW;
            end else if (cmd_q == CMD_SWAP) begin
              fin         = 1'b0;
              cmd_o.wr_en = 1'b1;
              cmd_o.wa    = WA_M2;
              cmd_o.wd    = WD_R;
              state_d     = S_WR2;
            end else begin
              cmd_o.wr_en = 1'b1;
              cmd_o.wa    = WA_M2;
              cmd_o.wd    = WD_ALU;
              cmd_o.cnt   = CNT_DEC1;
            end
          end
          CMD_NOT: begin
            if (stat_i.cnt_zero) begin
              st = ST_EMPTY;
            end else if (!stat_i.r_bool) begin
              st        = ST_NOT_BOOL;
              cmd_o.cnt = CNT_DEC1;
            end else begin
              cmd_o.wr_en = 1'b1;
              cmd_o.wa    = WA_M1;
              cmd_o.wd    = WD_ALU;
            end
          end
          CMD_PRINT: begin
            if (stat_i.cnt_zero) st = ST_EMPTY;
            else cmd_o.print = 1'b1;
          end
          CMD_CLEAR: cmd_o.cnt = CNT_CLR;
          CMD_DROP: begin
            if (stat_i.cnt_zero) st = ST_EMPTY;
            else cmd_o.cnt = CNT_DEC1;
          end
          CMD_DUP: begin
            if (stat_i.cnt_zero) begin
              st = ST_EMPTY;
            end else if (stat_i.full) begin
              st = ST_FULL;
            end else begin
              cmd_o.wr_en = 1'b1;
              cmd_o.wa    = WA_TOP;
              cmd_o.wd    = WD_R;
              cmd_o.cnt   = CNT_INC;
            end
          end
          default: ;
        endcase
      end
      S_DIVW: begin
        if (stat_i.div_done) begin
          fin         = 1'b1;
          cmd_o.wr_en = 1'b1;
          cmd_o.wa    = WA_M2;
          cmd_o.wd    = WD_ALU;
          cmd_o.cnt   = CNT_DEC1;
          state_d     = S_IDLE;
        end
      end
      S_WR2: begin
        fin         = 1'b1;
        cmd_o.wr_en = 1'b1;
        cmd_o.wa    = WA_M1;
        cmd_o.wd    = WD_L;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    cmd_o.out_load = fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cmd_q    <= CMD_PUSH_INT;
      done_q   <= 1'b0;
      status_q <= ST_OK;
    end else begin
      state_q <= state_d;
      done_q  <= fin;
      if (fin) status_q <= st;
      if (state_q == S_IDLE && start_i) cmd_q <= cmd_e'(command_i);
    end
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign status_o = status_q;

endmodule

[rtl/typed_rpn_stack_calculator.sv]
// Top level of the typed RPN stack calculator.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  request  | start / busy       | command_i, push_value_i
//  result   | done_o (1 cycle)   | status_o, print_*_o, stack_depth_o
//
// A request passes the read states and the execute state before the strobe;
// swap adds a second write state, div and mod wait for the bit-serial divider.
// Two registered reads of the entry RAM precede every command.
// Reset clears the depth counter; the entry RAM is not cleared.
// busy is high from acceptance until the strobe cycle; results cannot stall.
module typed_rpn_stack_calculator import trsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic [4:0]  command_i,
  input  logic [31:0] push_value_i,
  output logic        busy,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic        print_valid_o,
  output logic        print_is_bool_o,
  output logic [31:0] print_value_o,
  output logic [6:0]  stack_depth_o
);

  `include "typed_rpn_stack_calculator_assert.svh"

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  trsc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .command_i (command_i),
    .stat_i    (dp_stat),
    .cmd_o     (dp_cmd),
    .busy_o    (busy),
    .done_o    (done_o),
    .status_o  (status_o)
  );

  trsc_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .push_value_i    (push_value_i),
    .stat_o          (dp_stat),
    .print_valid_o   (print_valid_o),
    .print_is_bool_o (print_is_bool_o),
    .print_value_o   (print_value_o),
    .stack_depth_o   (stack_depth_o)
  );

  `TRSC_ASSERT(a_done_idle, !done_o || !busy, "result strobe while busy")
  `TRSC_ASSERT_NEXT(a_start_busy, start && !busy, busy, "request not taken")
  `TRSC_ASSERT_NEXT(a_done_pulse, done_o, !done_o, "result strobe longer than a cycle")
  `TRSC_ASSERT(a_print_ok, !(done_o && print_valid_o) || status_o == ST_OK,
               "print value with error status")

endmodule

[tb/calc_checker.sv]
// Checker for the typed RPN stack calculator: stack prediction and result comparison.
`timescale 1ns / 100ps
module calc_checker import trsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [4:0]  command_i,
  input  logic [31:0] push_value_i,
  input  logic        done_o,
  input  logic [2:0]  status_o,
  input  logic        print_valid_o,
  input  logic        print_is_bool_o,
  input  logic [31:0] print_value_o,
  input  logic [6:0]  stack_depth_o,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [2:0]  status;
    logic        pvalid;
    logic        pbool;
    logic [31:0] pvalue;
    logic [6:0]  depth;
  } calc_result_t;

  logic [32:0]  stack_mem [STACK_DEPTH];
  int           depth;
  calc_result_t result_q[$];

  function automatic logic pop(output logic [32:0] e);
    if (depth == 0) return 1'b0;
    depth--;
    e = stack_mem[depth];
    return 1'b1;
  endfunction

  function automatic logic [2:0] push(input logic [32:0] e);
    if (depth >= STACK_DEPTH) return ST_FULL;
    stack_mem[depth] = e;
    depth++;
    return ST_OK;
  endfunction

  function automatic calc_result_t calc_step(input logic [4:0] cmd, input logic [31:0] pv);
    calc_result_t res;
    logic [32:0]  a, b;
    logic signed [31:0] ls, rs;
    logic [31:0] v;
    logic        bv;
    res = '0;
    res.status = ST_OK;
    case (cmd)
      CMD_PUSH_INT: res.status = push({1'b0, pv});
      CMD_TRUE:     res.status = push({1'b1, 32'd1});
      CMD_FALSE:    res.status = push({1'b1, 32'd0});
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD, CMD_LT, CMD_GT, CMD_LE, CMD_GE: begin
        if (!pop(b) || !pop(a)) res.status = ST_EMPTY;
        else if (a[32] || b[32]) res.status = ST_NOT_INT;
        else begin
          ls = a[31:0];
          rs = b[31:0];
          case (cmd)
            CMD_ADD: res.status = push({1'b0, a[31:0] + b[31:0]});
            CMD_SUB: res.status = push({1'b0, a[31:0] - b[31:0]});
            CMD_MUL: res.status = push({1'b0, a[31:0] * b[31:0]});
            CMD_DIV, CMD_MOD: begin
              if (rs == 0) res.status = ST_DIV_ZERO;
              else begin
                if (ls == 32'sh80000000 && rs == -1) v = (cmd == CMD_DIV) ? 32'h80000000 : 0;
                else if (cmd == CMD_DIV) v = ls / rs;
                else v = ls % rs;
                res.status = push({1'b0, v});
              end
            end
            default: begin
              case (cmd)
                CMD_LT:  bv = ls < rs;
                CMD_GT:  bv = ls > rs;
                CMD_LE:  bv = ls <= rs;
                default: bv = ls >= rs;
              endcase
              res.status = push({1'b1, 31'd0, bv});
            end
          endcase
        end
      end
      CMD_EQ: begin
        if (!pop(b) || !pop(a)) res.status = ST_EMPTY;
        else res.status = push({1'b1, 31'd0, a == b});
      end
      CMD_NOT: begin
        if (!pop(a)) res.status = ST_EMPTY;
        else if (!a[32]) res.status = ST_NOT_BOOL;
        else res.status = push({1'b1, 31'd0, ~a[0]});
      end
      CMD_SWAP: begin
        if (!pop(a) || !pop(b)) res.status = ST_EMPTY;
        else begin
          void'(push(a));
          res.status = push(b);
        end
      end
      CMD_PRINT: begin
        if (depth == 0) res.status = ST_EMPTY;
        else begin
          res.pvalid = 1'b1;
          res.pbool  = stack_mem[depth-1][32];
          res.pvalue = stack_mem[depth-1][31:0];
        end
      end
      CMD_CLEAR: depth = 0;
      CMD_DROP:  if (!pop(a)) res.status = ST_EMPTY;
      CMD_DUP: begin
        if (depth == 0) res.status = ST_EMPTY;
        else res.status = push(stack_mem[depth-1]);
      end
      default: ;
    endcase
    res.depth = depth[6:0];
    return res;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
    depth = 0;
  end

  always @(posedge clk_i) begin
    calc_result_t got, want;
    if (rst_ni) begin
      if (done_o) begin
        got = {status_o, print_valid_o, print_is_bool_o, print_value_o, stack_depth_o};
        if (result_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %h", got);
        end else begin
          want = result_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: status %0d/%0d pv %0b/%0b pb %0b/%0b val %h/%h depth %0d/%0d",
                       want.status, got.status, want.pvalid, got.pvalid, want.pbool, got.pbool,
                       want.pvalue, got.pvalue, want.depth, got.depth);
          end
        end
      end
      if (start && !busy) result_q.push_back(calc_step(command_i, push_value_i));
    end
    pending = result_q.size();
  end

endmodule

[tb/tb_top.sv]
// Testbench top: stimulus, clock, reset and verdict for the stack calculator.
`timescale 1ns / 100ps
module tb_top;
  import trsc_pkg::*;

  logic        clk_i, rst_ni, start;
  logic [4:0]  command_i;
  logic [31:0] push_value_i;
  logic        busy, done_o, print_valid_o, print_is_bool_o;
  logic [2:0]  status_o;
  logic [31:0] print_value_o;
  logic [6:0]  stack_depth_o;
  int          fail_count, pending, cycles, idle_pct;

  typed_rpn_stack_calculator u_top (.*);
  calc_checker u_chk (.*);

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 400000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // called at a falling edge; busy is stable there, so a low busy means the
  // next rising edge takes the request
  task automatic send(input logic [4:0] cmd, input logic [31:0] val);
    while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    start = 1; command_i = cmd; push_value_i = val;
    while (busy) @(negedge clk_i);
    @(negedge clk_i);
    start = 0;
    command_i = 5'($urandom); push_value_i = $urandom;
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(5))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'hffffffff;
      3: return $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [4:0] rand_cmd();
    int r;
    r = $urandom_range(99);
    if (r < 30) return CMD_PUSH_INT;
    if (r < 36) return $urandom_range(1) ? CMD_TRUE : CMD_FALSE;
    if (r < 38) return CMD_CLEAR;
    if (r < 40) return 5'($urandom_range(31, 19));
    return 5'($urandom_range(18, 3));
  endfunction

  initial begin
    cycles = 0; idle_pct = 0;
    start = 0; command_i = 0; push_value_i = 0;
    rst_ni = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    // directed: empty-stack errors, extremes, min/-1, type errors, swap on three entries
    send(CMD_PRINT, 0); send(CMD_ADD, 0); send(CMD_DROP, 0); send(CMD_DUP, 0);
    send(CMD_NOT, 0);
    send(CMD_PUSH_INT, 32'h80000000); send(CMD_PUSH_INT, 32'hffffffff); send(CMD_DIV, 0);
    send(CMD_PRINT, 0);
    send(CMD_PUSH_INT, 32'h80000000); send(CMD_PUSH_INT, 32'hffffffff); send(CMD_MOD, 0);
    send(CMD_PUSH_INT, 32'h7fffffff); send(CMD_PUSH_INT, 0); send(CMD_DIV, 0);
    send(CMD_TRUE, 0); send(CMD_PUSH_INT, 5); send(CMD_SUB, 0);
    send(CMD_TRUE, 0); send(CMD_NOT, 0); send(CMD_PRINT, 0); send(CMD_SWAP, 0);
    send(CMD_PUSH_INT, -7); send(CMD_NOT, 0); send(5'd21, 0);
    repeat (STACK_DEPTH + 1) send(CMD_PUSH_INT, $urandom);
    send(CMD_DUP, 0); send(CMD_TRUE, 0); send(CMD_EQ, 0); send(CMD_CLEAR, 0);
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 18 : (ph == 1) ? 78 : 0;
      for (int i = 0; i < 560; i++) begin
        if (i == 200) while (pending != 0) @(negedge clk_i);
        send(rand_cmd(), rand_val());
      end
    end
    while (pending != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
